FILE: rtl/cba_pkg.sv
// ---------------------------------------------------------------------------
// cba_pkg
// Shared types and constants for the cluster bitmap allocator.
// ---------------------------------------------------------------------------
package cba_pkg;

   // request codes
   localparam logic REQ_FIND   = 1'b0;
   localparam logic REQ_UPDATE = 1'b1;

   // field and counter widths
   localparam int CLUSTER_W = 10;   // cluster field
   localparam int MASK_W    = 15;   // block occupancy mask field
   localparam int COUNT_W   = 11;   // cluster_count register
   localparam int POS_W     = 12;   // search position, holds bound plus a byte
   localparam int BYTE_W    = 10;   // byte counter during a scan
   localparam int J_W       = BYTE_W + 3;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;
   localparam logic [7:0]         BYTE_MSB    = 8'h80;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND_RD,
      ST_SCAN,
      ST_UPD_RD,
      ST_UPD_MOD,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic       hit;       // some cluster in the byte is free and in range
      logic [2:0] bit_pos;   // first such cluster, 0 = MSB of the byte
   } scan_result_type;

endpackage

FILE: rtl/cba_bitmap_ram.sv
// ---------------------------------------------------------------------------
// cba_bitmap_ram
// Single-port-write, single-port-read byte memory holding the full bitmap.
// ---------------------------------------------------------------------------
module cba_bitmap_ram #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/cba_byte_scan.sv
// ---------------------------------------------------------------------------
// cba_byte_scan
// Finds the first clear bit of one bitmap byte whose cluster lies in
// [lo, bound), scanning MSB first.
// ---------------------------------------------------------------------------
module cba_byte_scan
   import cba_pkg::*;
(
   input  logic [7:0]        byte_data,
   input  logic [BYTE_W-1:0] byte_index,
   input  logic [POS_W-1:0]  lo,
   input  logic [POS_W-1:0]  bound,
   output scan_result_type   result
);

   logic [7:0] free_vec;

   always_comb begin
      logic [J_W-1:0] j;
      for (int k = 0; k < 8; k++) begin
         j = {byte_index, 3'(k)};
         free_vec[k] = !byte_data[7-k]
                       && (j >= J_W'(lo))
                       && (j <  J_W'(bound));
      end
   end

   // lowest k wins: walk down so the last hit written is the first cluster
   always_comb begin
      result.hit     = |free_vec;
      result.bit_pos = 3'd0;
      for (int k = 7; k >= 0; k--) begin
         if (free_vec[k]) begin
            result.bit_pos = 3'(k);
         end
      end
   end

endmodule

FILE: rtl/cluster_bitmap_allocator_unit.sv
// ---------------------------------------------------------------------------
// cluster_bitmap_allocator_unit
// Next-fit free cluster search and full-mark update over a bitmap memory.
// ---------------------------------------------------------------------------
//
//  channel   ports                                          direction
//  -------   ---------------------------------------------  ---------
//  req       req_valid/ready, req_type, req_cluster,         in
//            req_block_used_mask
//  rsp       rsp_valid/ready, rsp_found, rsp_free_cluster,   out
//            rsp_mark_changed
//  csr       csr_valid/ready, csr_cluster_count              in
//
//  One request is in flight at a time. A find reads bitmap bytes out of
//  the bitmap memory one per cycle, stopping at the first free cluster or
//  the bound, and then responds. An update is a read-modify-write of one
//  byte. A find that starts at or past the bound, or an update beyond the
//  bitmap, skips the memory and goes straight to the response.
//  After reset a clearing pass writes zero to every bitmap byte, one per
//  cycle; requests wait for it, csr writes are taken throughout. A response
//  that is not taken holds in the output register and the finished request
//  waits for it to drain.
//
module cluster_bitmap_allocator_unit
   import cba_pkg::*;
#(
   parameter int MAX_CLUSTERS       = 1024,
   parameter int BLOCKS_PER_CLUSTER = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_type,
   input  logic [CLUSTER_W-1:0] req_cluster,
   input  logic [MASK_W-1:0]    req_block_used_mask,
   // response channel
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_found,
   output logic [CLUSTER_W-1:0] rsp_free_cluster,
   output logic                 rsp_mark_changed,
   // configuration
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [COUNT_W-1:0]   csr_cluster_count
);

   localparam int MAP_BYTES = (MAX_CLUSTERS + 7) / 8;
   localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);
   localparam logic [63:0]   DATA_MASK =
      (64'd1 << (BLOCKS_PER_CLUSTER - 1)) - 64'd1;

   // control registers
   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_addr_ff, clr_addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0]   cluster_count_ff;

   // working registers
   logic [BYTE_W-1:0]    rd_byte_ff, rd_byte_in;
   logic [BYTE_W-1:0]    chk_byte_ff, chk_byte_in;
   logic [POS_W-1:0]     lo_ff, lo_in;
   logic [POS_W-1:0]     bound_ff, bound_in;
   logic [CLUSTER_W-1:0] cluster_ff, cluster_in;
   logic [MASK_W-1:0]    mask_ff, mask_in;
   logic                 res_found_ff, res_found_in;
   logic [CLUSTER_W-1:0] res_idx_ff, res_idx_in;
   logic                 res_changed_ff, res_changed_in;
   logic                 rsp_found_ff, rsp_found_in;
   logic [CLUSTER_W-1:0] rsp_free_cluster_ff, rsp_free_cluster_in;
   logic                 rsp_mark_changed_ff, rsp_mark_changed_in;

   // memory port
   logic                 ram_wr_en;
   logic [AW-1:0]        ram_wr_addr;
   logic [7:0]           ram_wr_data;
   logic                 ram_rd_en;
   logic [AW-1:0]        ram_rd_addr;
   logic [7:0]           ram_rd_data;

   // search helpers
   logic [POS_W-1:0]     bound_now;
   logic [POS_W-1:0]     start_pos;
   scan_result_type      scan_res;
   logic [J_W:0]         byte_end;
   logic                 block_avail;
   logic                 is_full;
   logic [7:0]           bit_sel;

   cba_bitmap_ram #(
      .DEPTH (MAP_BYTES),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   cba_byte_scan u_scan (
      .byte_data  (ram_rd_data),
      .byte_index (chk_byte_ff),
      .lo         (lo_ff),
      .bound      (bound_ff),
      .result     (scan_res)
   );

   // search bound: the register clipped to the bitmap size
   always_comb begin
      if (32'(cluster_count_ff) > MAX_CLUSTERS) begin
         bound_now = POS_W'(MAX_CLUSTERS);
      end else begin
         bound_now = POS_W'(cluster_count_ff);
      end
   end

   assign start_pos = POS_W'(req_cluster) + POS_W'(1);
   // one past the last cluster of the byte under check
   assign byte_end  = {1'b0, chk_byte_ff, 3'b111} + (J_W+1)'(1);

   // update decision on the byte just read
   assign bit_sel     = BYTE_MSB >> cluster_ff[2:0];
   assign is_full     = |(ram_rd_data & bit_sel);
   assign block_avail = (64'(mask_ff) & DATA_MASK) != DATA_MASK;

   always_comb begin
      state_in            = state_ff;
      clr_addr_in         = clr_addr_ff;
      rd_byte_in          = rd_byte_ff;
      chk_byte_in         = chk_byte_ff;
      lo_in               = lo_ff;
      bound_in            = bound_ff;
      cluster_in          = cluster_ff;
      mask_in             = mask_ff;
      res_found_in        = res_found_ff;
      res_idx_in          = res_idx_ff;
      res_changed_in      = res_changed_ff;
      rsp_found_in        = rsp_found_ff;
      rsp_free_cluster_in = rsp_free_cluster_ff;
      rsp_mark_changed_in = rsp_mark_changed_ff;
      // drop the response once taken
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;

      req_ready   = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = clr_addr_ff;
      ram_wr_data = 8'd0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = '0;

      case (state_ff)
         ST_CLEAR: begin
            // sweep zeros through the bitmap: every cluster free
            ram_wr_en = 1'b1;
            if (clr_addr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + AW'(1);
            end
         end

         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cluster_in     = req_cluster;
               mask_in        = req_block_used_mask;
               lo_in          = start_pos;
               bound_in       = bound_now;
               res_found_in   = 1'b0;
               res_idx_in     = '0;
               res_changed_in = 1'b0;
               if (req_type == REQ_FIND) begin
                  // start at or past the bound finds nothing
                  if (start_pos >= bound_now) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_FIND_RD;
                  end
               end else begin
                  // clusters beyond the bitmap are ignored
                  if (32'(req_cluster) < MAX_CLUSTERS) begin
                     state_in = ST_UPD_RD;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end

         ST_FIND_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(lo_ff[POS_W-1:3]);
            chk_byte_in = BYTE_W'(lo_ff[POS_W-1:3]);
            rd_byte_in  = BYTE_W'(lo_ff[POS_W-1:3]) + BYTE_W'(1);
            state_in    = ST_SCAN;
         end

         ST_SCAN: begin
            // check one byte per cycle while the next one is read
            if (scan_res.hit) begin
               res_found_in = 1'b1;
               res_idx_in   = CLUSTER_W'({chk_byte_ff, scan_res.bit_pos});
               state_in     = ST_DONE;
            end else if (byte_end >= (J_W+1)'(bound_ff)) begin
               state_in = ST_DONE;
            end else begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = AW'(rd_byte_ff);
               chk_byte_in = rd_byte_ff;
               rd_byte_in  = rd_byte_ff + BYTE_W'(1);
            end
         end

         ST_UPD_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = AW'(cluster_ff[CLUSTER_W-1:3]);
            state_in    = ST_UPD_MOD;
         end

         ST_UPD_MOD: begin
            // flip the full bit only when it disagrees with the mask
            ram_wr_addr = AW'(cluster_ff[CLUSTER_W-1:3]);
            if (!block_avail && !is_full) begin
               ram_wr_en      = 1'b1;
               ram_wr_data    = ram_rd_data | bit_sel;
               res_changed_in = 1'b1;
            end else if (block_avail && is_full) begin
               ram_wr_en      = 1'b1;
               ram_wr_data    = ram_rd_data & ~bit_sel;
               res_changed_in = 1'b1;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_found_in        = res_found_ff;
               rsp_free_cluster_in = res_idx_ff;
               rsp_mark_changed_in = res_changed_ff;
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_addr_ff      <= '0;
         rsp_valid_ff     <= 1'b0;
         cluster_count_ff <= COUNT_RESET;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            cluster_count_ff <= csr_cluster_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_byte_ff          <= rd_byte_in;
      chk_byte_ff         <= chk_byte_in;
      lo_ff               <= lo_in;
      bound_ff            <= bound_in;
      cluster_ff          <= cluster_in;
      mask_ff             <= mask_in;
      res_found_ff        <= res_found_in;
      res_idx_ff          <= res_idx_in;
      res_changed_ff      <= res_changed_in;
      rsp_found_ff        <= rsp_found_in;
      rsp_free_cluster_ff <= rsp_free_cluster_in;
      rsp_mark_changed_ff <= rsp_mark_changed_in;
   end

   assign csr_ready        = 1'b1;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_free_cluster = rsp_free_cluster_ff;
   assign rsp_mark_changed = rsp_mark_changed_ff;

endmodule

FILE: dv/tb_cluster_bitmap_allocator_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_cluster_bitmap_allocator_unit
// Self-checking bench for the cluster bitmap allocator: a bit-accurate
// predictor of the full bitmap tracks every accepted request word, and each
// response word is checked field by field against the oldest prediction.
// Traffic mixes directed corner cases with byte-aligned fill runs, random
// updates and searches over several cluster_count settings, under bursty
// request timing and a stalling response side.
// ---------------------------------------------------------------------------
module tb_cluster_bitmap_allocator_unit;
   import cba_pkg::*;

   localparam int MAX_CLUSTERS       = 1024;
   localparam int BLOCKS_PER_CLUSTER = 16;
   localparam int MAP_BYTES          = (MAX_CLUSTERS + 7) / 8;
   // only the low BLOCKS_PER_CLUSTER-1 bits of the mask count as data blocks
   localparam logic [MASK_W-1:0] DATA_MASK = MASK_W'((1 << (BLOCKS_PER_CLUSTER - 1)) - 1);

   localparam int STALL_LIMIT  = 4000;   // cycles with no handshake at all
   localparam int DRAIN_CYCLES = 200;    // settle time after the last word
   localparam int ITEMS_TOTAL  = 1550;
   localparam int NUM_PHASES   = 9;
   localparam int HOLD_AFTER   = 400;    // responses seen before the long hold
   localparam int HOLD_CYCLES  = 300;

   typedef enum logic [1:0] {
      RX_OPEN,       // always ready
      RX_COIN,       // ready on a fair coin
      RX_PERIODIC,   // drop ready one cycle in four
      RX_SPARSE      // ready about one cycle in eight
   } rx_mode_type;

   typedef struct packed {
      logic                 kind;
      logic [CLUSTER_W-1:0] cluster;
      logic [MASK_W-1:0]    mask;
   } req_word_type;

   typedef struct packed {
      logic                 found;
      logic [CLUSTER_W-1:0] free_cluster;
      logic                 mark_changed;
   } rsp_word_type;

   // DUT inputs, all driven to known values from time zero
   logic                 clock               = 1'b0;
   logic                 reset               = 1'b1;
   logic                 req_valid           = 1'b0;
   logic                 req_ready;
   logic                 req_type            = REQ_FIND;
   logic [CLUSTER_W-1:0] req_cluster         = '0;
   logic [MASK_W-1:0]    req_block_used_mask = '0;
   logic                 rsp_valid;
   logic                 rsp_ready           = 1'b0;
   logic                 rsp_found;
   logic [CLUSTER_W-1:0] rsp_free_cluster;
   logic                 rsp_mark_changed;
   logic                 csr_valid           = 1'b0;
   logic                 csr_ready;
   logic [COUNT_W-1:0]   csr_cluster_count   = '0;

   // predictor state: shadow bitmap and shadow cluster_count
   logic [7:0]         full_map [MAP_BYTES];
   logic [COUNT_W-1:0] model_count = COUNT_RESET;

   req_word_type pending_words[$];   // words waiting to be offered
   rsp_word_type expected_rsp[$];    // predicted responses, oldest first

   int cluster_counts [NUM_PHASES] = '{1024, 1, 0, 2047, 13, 700, 1023, 64, 1024};

   int errors        = 0;
   int finds_sent    = 0;
   int find_hits     = 0;
   int updates_sent  = 0;
   int mark_flips    = 0;
   int settings_done = 0;
   int rsp_seen      = 0;
   int stall_cycles  = 0;

   // sender burst state
   int burst_left = 0;
   int gap_left   = 0;

   // receiver pattern state
   rx_mode_type rx_mode     = RX_OPEN;
   int          rx_mode_age = 0;
   int          rx_cycle    = 0;
   int          hold_left   = 0;
   logic        hold_done   = 1'b0;

   cluster_bitmap_allocator_unit #(
      .MAX_CLUSTERS       (MAX_CLUSTERS),
      .BLOCKS_PER_CLUSTER (BLOCKS_PER_CLUSTER)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_type            (req_type),
      .req_cluster         (req_cluster),
      .req_block_used_mask (req_block_used_mask),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_found           (rsp_found),
      .rsp_free_cluster    (rsp_free_cluster),
      .rsp_mark_changed    (rsp_mark_changed),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_cluster_count   (csr_cluster_count)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Advance the shadow bitmap by one request word and return the response
   // the block must produce for it.
   function automatic rsp_word_type apply_request(input req_word_type w);
      rsp_word_type r;
      int           bound;
      int           pos;
      int           c;
      int           byte_ix;
      int           bit_ix;
      logic         block_avail;
      logic         was_full;
      r = '0;
      c = int'(w.cluster);
      if (w.kind == REQ_FIND) begin
         // search strictly after the start, below min(count, MAX_CLUSTERS);
         // skipping full bytes whole gives the same answer as a bit walk
         bound = (int'(model_count) > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(model_count);
         pos = c + 1;
         while (pos < bound && !r.found) begin
            if (!full_map[pos >> 3][7 - (pos & 7)]) begin
               r.found        = 1'b1;
               r.free_cluster = pos[CLUSTER_W-1:0];
            end
            pos = pos + 1;
         end
      end else begin
         // MSB-first: cluster c lives in bit 7 - c%8 of byte c/8;
         // updates past cluster_count still land in the map
         byte_ix     = c >> 3;
         bit_ix      = 7 - (c & 7);
         block_avail = (w.mask & DATA_MASK) != DATA_MASK;
         was_full    = full_map[byte_ix][bit_ix];
         if (block_avail == was_full) begin
            full_map[byte_ix][bit_ix] = !block_avail;
            r.mark_changed = 1'b1;
         end
      end
      return r;
   endfunction

   task automatic queue_word(input logic kind, input int c, input int m);
      req_word_type w;
      w.kind    = kind;
      w.cluster = c[CLUSTER_W-1:0];
      w.mask    = m[MASK_W-1:0];
      pending_words.push_back(w);
   endtask

   // Hold until every queued word is taken and every response is back.
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_rsp.size() != 0);
   endtask

   task automatic write_cluster_count(input int value);
      @(posedge clock);
      csr_valid         <= 1'b1;
      csr_cluster_count <= value[COUNT_W-1:0];
      do @(posedge clock); while (!csr_ready);
      model_count = value[COUNT_W-1:0];
      csr_valid   <= 1'b0;
      settings_done++;
   endtask

   // Random traffic for one phase. Most of it aims at a hot range (below the
   // search bound, or the first 16 clusters) so that searches meet full bits,
   // whole full bytes and an exhausted map; the rest roams every cluster.
   task automatic load_random(input int n, input int count_val);
      int made;
      int hot;
      int choice;
      int first;
      int len;
      int c;
      int m;
      made = 0;
      hot  = (count_val > MAX_CLUSTERS) ? MAX_CLUSTERS : count_val;
      if (hot < 16) hot = 16;
      while (made < n) begin
         choice = $urandom_range(0, 9);
         if (choice < 2) begin
            // byte-aligned fill run, then search across it
            first = 8 * $urandom_range(0, (hot - 1) / 8);
            len   = $urandom_range(8, 24);
            for (int k = 0; k < len; k++) begin
               c = first + k;
               if (c < MAX_CLUSTERS) begin
                  // now and then punch a hole into the run
                  m = ($urandom_range(0, 5) == 0) ? $urandom_range(0, DATA_MASK)
                                                  : DATA_MASK;
                  queue_word(REQ_UPDATE, c, m);
                  made++;
               end
            end
            queue_word(REQ_FIND, (first == 0) ? 0 : first - 1, $urandom_range(0, DATA_MASK));
            made++;
         end else if (choice < 6) begin
            c = ($urandom_range(0, 9) < 7) ? $urandom_range(0, hot - 1)
                                           : $urandom_range(0, MAX_CLUSTERS - 1);
            m = ($urandom_range(0, 1) == 0) ? DATA_MASK : $urandom_range(0, DATA_MASK);
            queue_word(REQ_UPDATE, c, m);
            made++;
         end else begin
            case ($urandom_range(0, 7))
               0:       c = 0;
               1:       c = MAX_CLUSTERS - 1;
               2:       c = hot - 1;
               3:       c = $urandom_range(0, MAX_CLUSTERS - 1);
               default: c = $urandom_range(0, hot - 1);
            endcase
            queue_word(REQ_FIND, c, $urandom_range(0, DATA_MASK));
            made++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Request driver: offer pending words in bursts with random gaps. Valid
   // holds with a stable payload until the word is taken.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      logic         next_valid;
      rsp_word_type predicted;
      req_word_type taken;
      req_word_type nxt;
      next_valid = req_valid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            // the word just taken is the head of the pending queue
            taken     = pending_words.pop_front();
            predicted = apply_request(taken);
            expected_rsp.push_back(predicted);
            if (taken.kind == REQ_FIND) begin
               finds_sent++;
               if (predicted.found) find_hits++;
            end else begin
               updates_sent++;
               if (predicted.mark_changed) mark_flips++;
            end
            next_valid = 1'b0;
            if (burst_left > 0) burst_left--;
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (burst_left == 0) begin
               // start a new burst; a third of them come without a gap
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end
            if (gap_left == 0 && burst_left > 0 && pending_words.size() != 0) begin
               nxt                 = pending_words[0];
               next_valid          = 1'b1;
               req_type            <= nxt.kind;
               req_cluster         <= nxt.cluster;
               req_block_used_mask <= nxt.mask;
            end
         end
      end
      req_valid <= next_valid;
   end

   // ------------------------------------------------------------------------
   // Response monitor: check each taken word against the oldest prediction,
   // and drive rsp_ready from a random pattern that rx_mode_age redraws. Once,
   // after HOLD_AFTER responses, drop ready for HOLD_CYCLES so the block backs
   // up and stalls its request side while the driver keeps offering.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      rsp_word_type want;
      logic         next_ready;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected response word: found=%0d free_cluster=%0d mark_changed=%0d",
                   rsp_found, rsp_free_cluster, rsp_mark_changed);
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            if (rsp_found !== want.found) begin
               $error("found: expected %0d, actual %0d", want.found, rsp_found);
               errors++;
            end
            if (rsp_free_cluster !== want.free_cluster) begin
               $error("free_cluster: expected %0d, actual %0d",
                      want.free_cluster, rsp_free_cluster);
               errors++;
            end
            if (rsp_mark_changed !== want.mark_changed) begin
               $error("mark_changed: expected %0d, actual %0d",
                      want.mark_changed, rsp_mark_changed);
               errors++;
            end
         end
         rsp_seen++;
      end

      rx_cycle++;
      rx_mode_age++;
      if (rx_mode_age == 100) begin
         rx_mode_age = 0;
         rx_mode     = rx_mode_type'($urandom_range(0, 3));
      end

      if (hold_left > 0) begin
         hold_left--;
         next_ready = 1'b0;
      end else if (!hold_done && rsp_seen >= HOLD_AFTER) begin
         hold_done  = 1'b1;
         hold_left  = HOLD_CYCLES;
         next_ready = 1'b0;
      end else begin
         case (rx_mode)
            RX_OPEN:     next_ready = 1'b1;
            RX_COIN:     next_ready = 1'($urandom_range(0, 1));
            RX_PERIODIC: next_ready = (rx_cycle % 4) != 0;
            default:     next_ready = ($urandom_range(0, 7) == 0);
         endcase
      end
      rsp_ready <= next_ready;
   end

   // Watchdog: end the run if no channel moves a word for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus sequencer
   // ------------------------------------------------------------------------
   initial begin : stimulus
      // the block clears its map at reset: every cluster starts free
      foreach (full_map[i]) full_map[i] = 8'h00;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part, run with the reset cluster_count of 1024.
      queue_word(REQ_FIND,   0,    0);           // start 0 never returns 0
      queue_word(REQ_FIND,   1023, 0);           // start at the bound
      queue_word(REQ_FIND,   1022, DATA_MASK);   // last cluster free
      queue_word(REQ_UPDATE, 0,    DATA_MASK);   // set full mark
      queue_word(REQ_UPDATE, 0,    DATA_MASK);   // already full
      queue_word(REQ_UPDATE, 0,    15'h7FFE);    // one block free: clear
      queue_word(REQ_UPDATE, 0,    15'h0000);    // already clear
      for (int c = 8; c < 16; c++) queue_word(REQ_UPDATE, c, DATA_MASK);
      queue_word(REQ_FIND,   7,    0);           // skip a whole full byte
      queue_word(REQ_UPDATE, 16,   15'h3FFF);    // free cluster stays free
      queue_word(REQ_UPDATE, 1023, DATA_MASK);
      queue_word(REQ_FIND,   1022, 0);           // nothing free after start
      queue_word(REQ_UPDATE, 1,    DATA_MASK);
      queue_word(REQ_FIND,   0,    15'h5555);    // first free is 2
      queue_word(REQ_UPDATE, 1023, 15'h5555);    // clear the last cluster
      queue_word(REQ_FIND,   1022, 15'h2AAA);
      queue_word(REQ_UPDATE, 1000, 15'h2AAA);
      wait_idle();

      // Random phases, one per cluster_count setting, extremes included.
      for (int p = 0; p < NUM_PHASES; p++) begin
         write_cluster_count(cluster_counts[p]);
         @(negedge clock);
         load_random(ITEMS_TOTAL / NUM_PHASES, cluster_counts[p]);
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d finds (%0d found a cluster) and %0d updates (%0d flipped a mark)",
               finds_sent, find_hits, updates_sent, mark_flips);
      $display("across %0d cluster_count writes, with one long response stall",
               settings_done);
      if (errors == 0 && expected_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
